// ===== rtl/core/mgs_pkg.sv =====
package mgs_pkg;

  // sequence warm-up length and counter width
  localparam int unsigned WarmupSteps = 1600;
  localparam int unsigned WarmW       = $clog2(WarmupSteps);

  // divider operand widths
  localparam int unsigned DivW  = 12;
  localparam int unsigned DsrW  = 4;
  localparam int unsigned DivCw = $clog2(DivW);

  localparam logic [DsrW-1:0] Ten       = 4'd10;
  localparam logic [DsrW-1:0] NaccOne   = 4'd1;
  localparam logic [DsrW-1:0] NaccFdd   = 4'd4;
  localparam logic [DsrW-1:0] NaccTdd   = 4'd10;
  localparam logic [10:0]     IdeltaTdd = 11'd8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCRAMBLING_ID   = 2'd0,
    REG_START_SUBFRAME  = 2'd1,
    REG_COVERAGE_MODE_B = 2'd2,
    REG_TDD_FRAME       = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_J0,
    ST_DIV_J,
    ST_DIV_MOD,
    ST_WARM,
    ST_EMIT
  } state_t;

  // requests to and status from the shared divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DsrW-1:0] remainder;
  } div_stat_t;

  // one step of the first register: x1(n+31) = x1(n+3) ^ x1(n)
  function automatic logic [30:0] step_first(input logic [30:0] a);
    return {a[3] ^ a[0], a[30:1]};
  endfunction

  // one step of the second register: taps at 3, 2, 1 and 0
  function automatic logic [30:0] step_second(input logic [30:0] b);
    return {b[3] ^ b[2] ^ b[1] ^ b[0], b[30:1]};
  endfunction

endpackage

// ===== rtl/core/mgs_div.sv =====
module mgs_div
  import mgs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic            running;
  logic            done;
  logic [DivCw-1:0] count;
  logic [DivW-1:0] quo;
  logic [DsrW-1:0] rem;
  logic [DsrW-1:0] dsr;

  logic [DsrW:0]   trial;
  logic            ge;
  logic [DsrW:0]   diff;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[DivW-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  // advance the iteration and flag the cycle after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        if (count == DivCw'(DivW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  // hold operands and partial results
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (running) begin
      quo <= {quo[DivW-2:0], ge};
      rem <= ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.quotient  = quo;
  assign stat.remainder = rem;

endmodule

// ===== rtl/core/mpdcch_gold_scrambler_core.sv =====
// Gold sequence scrambler, one coded bit per input word. A word without
// block_start is scrambled and handed to the output register in the cycle it
// is accepted, so steady flow runs at one bit per cycle while the output is
// not stalled. A word with block_start reseeds the sequence: three passes of
// the shared shift-subtract divider (offset, block index, modulo ten; twelve
// quotient bits each, then a done strobe), then 1600 steps of register
// warm-up at one step per cycle, then the emit state, which loads the result
// once the output register is free. in_ready is low through the reseed and
// also while the output register stays full.
// Configuration is taken at any time on the cfg port but should be written
// only while idle.
module mpdcch_gold_scrambler_core
  import mgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       coded_bit,
  input  logic [9:0] subframe,
  input  logic       block_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scrambled_bit,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  state_t state, state_next;

  logic [8:0]  scrambling_id;
  logic [9:0]  start_subframe;
  logic        coverage_mode_b;
  logic        tdd_frame;

  logic [30:0] first_lfsr;
  logic [30:0] second_lfsr;
  logic [WarmW-1:0] warm_cnt;
  logic        hold_bit;
  logic [9:0]  hold_sf;
  logic [10:0] j0;

  logic        in_acc;
  logic        out_free;
  logic        seq_bit;
  logic [DsrW-1:0] nacc;
  logic [10:0] idelta;
  logic [10:0] jsum;
  logic [DivW-1:0] prod;
  logic [9:0]  sf_diff;

  div_req_t  dreq;
  div_stat_t dstat;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign seq_bit   = first_lfsr[0] ^ second_lfsr[0];

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scrambling_id   <= '0;
      start_subframe  <= '0;
      coverage_mode_b <= 1'b0;
      tdd_frame       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCRAMBLING_ID:   scrambling_id   <= cfg_data[8:0];
        REG_START_SUBFRAME:  start_subframe  <= cfg_data;
        REG_COVERAGE_MODE_B: coverage_mode_b <= cfg_data[0];
        REG_TDD_FRAME:       tdd_frame       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // accumulation length, offset and divider operands
  always_comb begin
    nacc   = coverage_mode_b ? (tdd_frame ? NaccTdd : NaccFdd) : NaccOne;
    idelta = (coverage_mode_b && tdd_frame) ? IdeltaTdd : 11'd0;
    sf_diff = hold_sf - start_subframe;
    jsum   = j0 + dstat.quotient[10:0];
    case (nacc)
      NaccFdd: prod = {jsum[9:0], 2'b00};
      NaccTdd: prod = {jsum, 1'b0} + {jsum[8:0], 3'b000};
      default: prod = {1'b0, jsum};
    endcase
  end

  // feed the shared divider
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = nacc;
    unique case (state)
      ST_IDLE: begin
        dreq.start    = in_acc && block_start;
        dreq.dividend = {1'b0, {1'b0, start_subframe} + idelta};
      end
      ST_DIV_J0: begin
        dreq.start    = dstat.done;
        dreq.dividend = {2'b00, sf_diff};
      end
      ST_DIV_J: begin
        dreq.start    = dstat.done;
        dreq.dividend = prod;
        dreq.divisor  = Ten;
      end
      default: ;
    endcase
  end

  mgs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .stat (dstat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_acc && block_start) state_next = ST_DIV_J0;
      ST_DIV_J0:  if (dstat.done) state_next = ST_DIV_J;
      ST_DIV_J:   if (dstat.done) state_next = ST_DIV_MOD;
      ST_DIV_MOD: if (dstat.done) state_next = ST_WARM;
      ST_WARM:    if (warm_cnt == WarmW'(WarmupSteps - 1)) state_next = ST_EMIT;
      ST_EMIT:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequence registers: reseed, warm up, advance per emitted word
  always_ff @(posedge clk) begin
    if (rst) begin
      first_lfsr  <= 31'd1;
      second_lfsr <= '0;
    end else if ((state == ST_DIV_MOD) && dstat.done) begin
      first_lfsr  <= 31'd1;
      second_lfsr <= 31'({dstat.remainder, 9'd0}) + 31'(scrambling_id);
    end else if ((state == ST_WARM) || ((state == ST_EMIT) && out_free) ||
                 (in_acc && !block_start)) begin
      first_lfsr  <= step_first(first_lfsr);
      second_lfsr <= step_second(second_lfsr);
    end
  end

  // hold each accepted word, intermediate results and the warm-up count
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_bit <= coded_bit;
      hold_sf  <= subframe;
    end
    if ((state == ST_DIV_J0) && dstat.done) j0 <= dstat.quotient[10:0];
    if (state == ST_WARM) warm_cnt <= warm_cnt + 1'b1;
    else                  warm_cnt <= '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_acc && !block_start) || ((state == ST_EMIT) && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !block_start) scrambled_bit <= coded_bit ^ seq_bit;
    else if ((state == ST_EMIT) && out_free) scrambled_bit <= hold_bit ^ seq_bit;
  end

endmodule

// ===== verif/tb_mpdcch_gold_scrambler_core.sv =====
module tb_mpdcch_gold_scrambler_core;
  import mgs_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBits  = 125;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       coded_bit = 1'b0;
  logic [9:0] subframe = '0;
  logic       block_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scrambled_bit;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  reg_index_t cfg_index = REG_SCRAMBLING_ID;
  logic [9:0] cfg_data = '0;

  // register copies and sequence state of the predictor
  logic [8:0]  cur_scr_id = '0;
  logic [9:0]  cur_start_sf = '0;
  logic        cur_mode_b = 1'b0;
  logic        cur_tdd = 1'b0;
  logic [30:0] gold_x1 = 31'd1;
  logic [30:0] gold_x2 = '0;

  // scrambled bits still owed by the block, oldest first
  logic        scrambled_due[$];
  logic        want_bit;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned phase_count = 0;

  mpdcch_gold_scrambler_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance both sequence registers by one position
  function automatic void gold_step();
    gold_x1 = {gold_x1[3] ^ gold_x1[0], gold_x1[30:1]};
    gold_x2 = {gold_x2[3] ^ gold_x2[2] ^ gold_x2[1] ^ gold_x2[0], gold_x2[30:1]};
  endfunction

  // reseed on a block start, then scramble one bit and move on
  function automatic logic gold_scramble(input logic b, input logic [9:0] sf,
                                         input logic st);
    int unsigned nacc;
    int unsigned idelta;
    int unsigned j0;
    int unsigned j;
    logic [9:0]  sf_diff;
    logic        seq_bit;
    if (st) begin
      nacc = 1;
      if (cur_mode_b) nacc = cur_tdd ? 10 : 4;
      idelta = (cur_tdd && nacc != 1) ? nacc - 2 : 0;
      // subframe distance wraps at 1024
      sf_diff = sf - cur_start_sf;
      j0 = (cur_start_sf + idelta) / nacc;
      j = sf_diff / nacc;
      gold_x1 = 31'd1;
      gold_x2 = 31'(((((j0 + j) * nacc) % 10) << 9) + cur_scr_id);
      repeat (WarmupSteps) gold_step();
    end
    seq_bit = gold_x1[0] ^ gold_x2[0];
    gold_step();
    return b ^ seq_bit;
  endfunction

  // offer one word, hold it until taken, then log its expected result
  task automatic send_bit(input logic b, input logic [9:0] sf, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    coded_bit   <= b;
    subframe    <= sf;
    block_start <= st;
    do @(posedge clk); while (!in_ready);
    scrambled_due.push_back(gold_scramble(b, sf, st));
  endtask

  // drop the input and drain every owed result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (scrambled_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SCRAMBLING_ID:   cur_scr_id   = val[8:0];
      REG_START_SUBFRAME:  cur_start_sf = val;
      REG_COVERAGE_MODE_B: cur_mode_b   = val[0];
      REG_TDD_FRAME:       cur_tdd      = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [8:0] scr, input logic [9:0] ssf,
                            input logic mode_b, input logic tdd);
    write_reg(REG_SCRAMBLING_ID, {1'b0, scr});
    write_reg(REG_START_SUBFRAME, ssf);
    write_reg(REG_COVERAGE_MODE_B, {9'd0, mode_b});
    write_reg(REG_TDD_FRAME, {9'd0, tdd});
  endtask

  // bits before any block start run from the reset register values
  task automatic test_unseeded_bits();
    send_bit(1'b0, 10'd0, 1'b0);
    send_bit(1'b1, 10'd1023, 1'b0);
    send_bit(1'b1, 10'd512, 1'b0);
    send_bit(1'b0, 10'd341, 1'b0);
    wait_idle();
  endtask

  // TDD long accumulation, subframe behind the start so the distance wraps
  task automatic test_tdd_wrap();
    set_config(9'd511, 10'd1000, 1'b1, 1'b1);
    send_bit(1'b1, 10'd3, 1'b1);
    send_bit(1'b0, 10'd1023, 1'b0);
    send_bit(1'b1, 10'd0, 1'b0);
    send_bit(1'b0, 10'd555, 1'b0);
    send_bit(1'b1, 10'd1023, 1'b1);
    wait_idle();
  endtask

  task automatic test_fdd_long();
    set_config(9'd503, 10'd1023, 1'b1, 1'b0);
    send_bit(1'b0, 10'd0, 1'b1);
    send_bit(1'b1, 10'd682, 1'b0);
    send_bit(1'b1, 10'd341, 1'b0);
    send_bit(1'b0, 10'd1, 1'b0);
    wait_idle();
  endtask

  // short accumulation in FDD and TDD, back-to-back block starts
  task automatic test_plain_blocks();
    set_config(9'd0, 10'd0, 1'b0, 1'b0);
    send_bit(1'b1, 10'd1023, 1'b1);
    send_bit(1'b0, 10'd1023, 1'b1);
    send_bit(1'b1, 10'd0, 1'b0);
    send_bit(1'b0, 10'd1, 1'b1);
    send_bit(1'b1, 10'd2, 1'b0);
    wait_idle();
    set_config(9'd257, 10'd682, 1'b0, 1'b1);
    send_bit(1'b1, 10'd341, 1'b1);
    send_bit(1'b0, 10'd0, 1'b0);
    send_bit(1'b1, 10'd1023, 1'b0);
    wait_idle();
  endtask

  // random blocks under several register settings
  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned p;
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    logic [8:0]  scr;
    logic [9:0]  ssf;
    logic [9:0]  sf;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (p = 0; p < 3; p++) begin
      case ($urandom_range(3))
        0: scr = 9'd0;
        1: scr = 9'd503;
        2: scr = 9'd511;
        default: scr = 9'($urandom_range(511));
      endcase
      case ($urandom_range(2))
        0: ssf = 10'd0;
        1: ssf = 10'd1023;
        default: ssf = 10'($urandom_range(1023));
      endcase
      // walk every mode and frame combination first, then pick at random
      if (phase_count < 4)
        set_config(scr, ssf, phase_count[0], phase_count[1]);
      else
        set_config(scr, ssf, 1'($urandom_range(1)), 1'($urandom_range(1)));
      phase_count++;
      sent = 0;
      while (sent < PhaseBits) begin
        // start near the configured subframe, just behind it, or anywhere
        case ($urandom_range(3))
          0: sf = ssf;
          1: sf = ssf - 10'd1;
          2: sf = 10'($urandom_range(1023));
          default: sf = ssf + 10'($urandom_range(15));
        endcase
        send_bit(1'($urandom_range(1)), sf, 1'b1);
        sent++;
        run_len = ($urandom_range(7) == 0) ? $urandom_range(120) : $urandom_range(30);
        // the odd stray start breaks a block early
        for (k = 0; k < run_len && sent < PhaseBits; k++) begin
          send_bit(1'($urandom_range(1)), 10'($urandom_range(1023)),
                   1'($urandom_range(49) == 0));
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  // stall the output for a long stretch while words keep coming
  task automatic test_backpressure();
    int unsigned k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(9'd123, 10'd517, 1'b1, 1'b0);
    send_bit(1'b0, 10'd520, 1'b1);
    send_bit(1'b1, 10'd9, 1'b0);
    hold_seq++;
    for (k = 0; k < 150; k++)
      send_bit(1'($urandom_range(1)), 10'($urandom_range(1023)), 1'b0);
    wait_idle();
  endtask

  // output side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each delivered word with the oldest owed bit
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (scrambled_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected scrambled_bit=%0b at cycle %0d", scrambled_bit, cycle_count);
        mismatch_count++;
      end else begin
        want_bit = scrambled_due.pop_front();
        if (scrambled_bit !== want_bit) begin
          if (mismatch_count < 10)
            $display("scrambled_bit mismatch at cycle %0d: expected %0b, got %0b",
                     cycle_count, want_bit, scrambled_bit);
          mismatch_count++;
        end
      end
    end
  end

  // guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_mpdcch_gold_scrambler_core: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 54;
    test_unseeded_bits();
    test_tdd_wrap();
    test_fdd_long();
    test_plain_blocks();
    test_random_traffic(19, 54);
    test_random_traffic(54, 19);
    test_random_traffic(0, 0);
    test_backpressure();
    // let any stray late words show up
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && scrambled_due.size() == 0)
      $display("tb_mpdcch_gold_scrambler_core: clean");
    else
      $display("tb_mpdcch_gold_scrambler_core: errors");
    $finish;
  end

endmodule
